[sv/stable_three_level_priority_queue_top_defines.svh]
// Assertion macros shared by the priority queue modules.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef STABLE_THREE_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_THREE_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define STPQ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define STPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STPQ_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define STPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

[sv/stpq_pkg.sv]
`default_nettype none
package stpq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int RECORD_BITS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRI_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;

  // input action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // chain commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef struct packed {
    logic [PRI_W-1:0]       pri;
    logic [RECORD_BITS-1:0] rec;
  } slot_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [PRI_W-1:0]       pri;
    logic [RECORD_BITS-1:0] rec;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   popped_valid;
    logic [PRI_W-1:0]       popped_priority;
    logic [RECORD_BITS-1:0] popped_record;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage
`default_nettype wire

[sv/stpq_cell.sv]
`default_nettype none
// One slot of the sorted chain. Occupancy comes from comparing the slot
// index with the stored count.
module stpq_cell (
  input  wire                              clk,
  input  wire  [stpq_pkg::IDX_W-1:0]       cell_idx,
  input  wire  [stpq_pkg::CNT_W-1:0]       count,
  input  stpq_pkg::cmd_t                   cell_cmd,
  input  stpq_pkg::slot_t                  left_slot,
  input  wire                              left_keep,
  input  stpq_pkg::slot_t                  right_slot,
  output stpq_pkg::slot_t                  slot,
  output logic                             keep
);
  import stpq_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;
  logic  occupied;

  assign occupied = CNT_W'(cell_idx) < count;
  // keep own entry when it ranks equal or above the newcomer
  assign keep     = occupied && (slot_r.pri >= cell_cmd.pri);
  assign slot     = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    unique case (cell_cmd.op)
      CMD_INSERT: begin
        if (keep) begin
          slot_nxt = slot_r;
        end else if (left_keep) begin
          slot_nxt.pri = cell_cmd.pri;
          slot_nxt.rec = cell_cmd.rec;
        end else begin
          slot_nxt = left_slot;
        end
      end
      CMD_POP: begin
        slot_nxt = right_slot;
      end
      default: begin
        slot_nxt = slot_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule
`default_nettype wire

[sv/stpq_out.sv]
`default_nettype none
`include "stable_three_level_priority_queue_top_defines.svh"
// Result register plus one skid entry.
module stpq_out (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                load,
  input  stpq_pkg::res_t     load_res,
  output logic               load_ready,
  output logic               out_valid,
  input  wire                out_stall,
  output stpq_pkg::res_t     out_res
);
  import stpq_pkg::*;

  logic out_valid_r;
  logic skid_v_r;
  res_t out_res_r;
  res_t skid_r;
  logic out_take;

  assign out_take   = out_valid_r && !out_stall;
  assign load_ready = !skid_v_r;
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      // drain skid into the output stage
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (load) begin
      if (out_valid_r && !out_take) begin
        skid_v_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_res_r <= skid_r;
      end
    end else if (load) begin
      if (out_valid_r && !out_take) begin
        skid_r <= load_res;
      end else begin
        out_res_r <= load_res;
      end
    end
  end

  `STPQ_ASSERT(a_skid_behind_out, clk, rst_n, !skid_v_r || out_valid_r, "skid full with output empty")

endmodule
`default_nettype wire

[sv/stable_three_level_priority_queue_top.sv]
`default_nettype none
`include "stable_three_level_priority_queue_top_defines.svh"
// Stable three-level priority queue. Holds up to QUEUE_DEPTH entries
// (priority 1..3 plus a record handle) in a sorted row of slot cells, head
// in slot 0. An insert beat (action 0) lands behind every entry of equal or
// higher priority, so each level leaves in arrival order; priority 0 is
// rejected with status 1 and an insert into a full queue is dropped with
// status 2. A pop beat (action 1) returns the head and shifts the row up;
// a pop from an empty queue gives status 3. Every input beat produces
// exactly one result beat carrying the entry count after the operation.
// Throughput is one beat per cycle while in_stall is low: every cell
// compares its slot against the newcomer in parallel and loads from
// itself, its left neighbor, the input or its right neighbor, so the row
// update and the count update happen together. Each result is registered
// in the output register, or in the skid entry while the output stalls;
// in_stall rises only while both are full. Slot contents have no reset;
// only slots below the stored count are ever read.
module stable_three_level_priority_queue_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_action,
  input  wire  [stpq_pkg::PRI_W-1:0]           in_priority_req,
  input  wire  [stpq_pkg::RECORD_BITS-1:0]     in_record_id,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [stpq_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_popped_valid,
  output logic [stpq_pkg::PRI_W-1:0]           out_popped_priority,
  output logic [stpq_pkg::RECORD_BITS-1:0]     out_popped_record,
  output logic [stpq_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import stpq_pkg::*;

  logic             in_acc;
  logic             load_ready;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [1:0]       op;
  logic [31:0]      count_wide;
  cmd_t             cell_cmd;
  res_t             res;
  res_t             out_res;
  slot_t            ent_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep_w;

  assign in_stall = !load_ready;
  assign in_acc   = in_valid && load_ready;

  // Decode the beat: status, chain command and the next count.
  always_comb begin
    res                 = '0;
    op                  = CMD_HOLD;
    count_nxt           = count_r;
    res.status          = ST_OK;
    if (in_action == ACT_INSERT) begin
      if (in_priority_req == '0) begin
        res.status = ST_INVALID;
      end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        op        = CMD_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (count_r == '0) begin
        res.status = ST_EMPTY;
      end else begin
        op                  = CMD_POP;
        count_nxt           = count_r - CNT_W'(1);
        res.popped_valid    = 1'b1;
        res.popped_priority = ent_w[0].pri;
        res.popped_record   = ent_w[0].rec;
      end
    end
    count_wide      = 32'(count_nxt);
    res.entry_count = count_wide[COUNT_OUT_W-1:0];
  end

  // Drive the chain only on an accepted beat; otherwise every cell holds.
  assign cell_cmd.op  = in_acc ? op : CMD_HOLD;
  assign cell_cmd.pri = in_priority_req;
  assign cell_cmd.rec = in_record_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
    end
  end

  // Row of slot cells: insert shifts right from the landing slot, pop
  // shifts left toward the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_k;

    if (i == 0) begin : g_first
      assign left_s = '0;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_s = ent_w[i-1];
      assign left_k = keep_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = ent_w[i+1];
    end

    stpq_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .count      (count_r),
      .cell_cmd   (cell_cmd),
      .left_slot  (left_s),
      .left_keep  (left_k),
      .right_slot (right_s),
      .slot       (ent_w[i]),
      .keep       (keep_w[i])
    );
  end

  stpq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .load_res   (res),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_status          = out_res.status;
  assign out_popped_valid    = out_res.popped_valid;
  assign out_popped_priority = out_res.popped_priority;
  assign out_popped_record   = out_res.popped_record;
  assign out_entry_count     = out_res.entry_count;

  `STPQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `STPQ_ASSERT(a_tail_free, clk, rst_n, !(cell_cmd.op == CMD_INSERT && keep_w[QUEUE_DEPTH-1]), "insert with last slot occupied")
  `STPQ_ASSERT_NEXT(a_ins_grow, clk, rst_n, cell_cmd.op == CMD_INSERT, count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `STPQ_ASSERT_NEXT(a_pop_shift, clk, rst_n, cell_cmd.op == CMD_POP && count_r > CNT_W'(1), ent_w[0] == $past(ent_w[1]), "pop did not advance head")

endmodule
`default_nettype wire

[verif/stable_three_level_priority_queue_top_tb.sv]
`timescale 1ns / 100ps
module stable_three_level_priority_queue_top_tb;
  import stpq_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  // Longest correct quiet stretch is the long output hold or a run of sender
  // gaps at 80 percent idling; take that many times over.
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 64;
  localparam int TAIL_CYCLES  = 10;
  localparam int PHASE_BEATS  = 300;

  // Priority levels; zero marks an unset level and must be rejected.
  localparam logic [PRI_W-1:0] PRI_UNSET = 2'd0;
  localparam logic [PRI_W-1:0] PRI_LOW   = 2'd1;
  localparam logic [PRI_W-1:0] PRI_MID   = 2'd2;
  localparam logic [PRI_W-1:0] PRI_HIGH  = 2'd3;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_t;

  // Mirror of the sorted slot row plus the results it predicts, oldest first.
  class queue_order_scoreboard;
    logic [PRI_W-1:0]       slot_lvl [QUEUE_DEPTH];
    logic [RECORD_BITS-1:0] slot_rec [QUEUE_DEPTH];
    int   held;
    res_t awaited[$];
    int   errors;
    int   pops_returned;
    int   empty_pops;
    int   invalid_inserts;
    int   full_drops;
    int   peak_held;

    function void predict_beat(logic act, logic [PRI_W-1:0] pri,
                               logic [RECORD_BITS-1:0] rec);
      res_t r;
      int   pos;
      r   = '0;
      pos = 0;
      if (act == ACT_INSERT) begin
        if (pri == PRI_UNSET) begin
          r.status = ST_INVALID;
          invalid_inserts++;
        end else if (held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          // land behind every entry of equal or higher level
          while (pos < held && slot_lvl[pos] >= pri) pos++;
          for (int i = held; i > pos; i--) begin
            slot_lvl[i] = slot_lvl[i-1];
            slot_rec[i] = slot_rec[i-1];
          end
          slot_lvl[pos] = pri;
          slot_rec[pos] = rec;
          held++;
          if (held > peak_held) peak_held = held;
          r.status = ST_OK;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
        empty_pops++;
      end else begin
        r.status          = ST_OK;
        r.popped_valid    = 1'b1;
        r.popped_priority = slot_lvl[0];
        r.popped_record   = slot_rec[0];
        for (int i = 1; i < held; i++) begin
          slot_lvl[i-1] = slot_lvl[i];
          slot_rec[i-1] = slot_rec[i];
        end
        held--;
        pops_returned++;
      end
      r.entry_count = COUNT_OUT_W'(held);
      awaited.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result beat arrived with no result awaited");
        errors++;
        return;
      end
      want = awaited.pop_front();
      cmp_field("status",          32'(want.status),          32'(got.status));
      cmp_field("popped_valid",    32'(want.popped_valid),    32'(got.popped_valid));
      cmp_field("popped_priority", 32'(want.popped_priority), 32'(got.popped_priority));
      cmp_field("popped_record",   32'(want.popped_record),   32'(got.popped_record));
      cmp_field("entry_count",     32'(want.entry_count),     32'(got.entry_count));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_action       = ACT_INSERT;
  logic [PRI_W-1:0]       in_priority_req = PRI_UNSET;
  logic [RECORD_BITS-1:0] in_record_id    = '0;
  logic                   out_stall       = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic                   out_popped_valid;
  logic [PRI_W-1:0]       out_popped_priority;
  logic [RECORD_BITS-1:0] out_popped_record;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  res_t                   seen_result;

  queue_order_scoreboard sb;

  int idle_pct      = 0;   // sender gap chance per cycle, main process only
  int stall_pct     = 0;   // receiver stall chance, written with NBA
  int hold_request  = 0;   // bump to ask the receiver for one long hold
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int beats_offered = 0;

  stable_three_level_priority_queue_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_priority_req     (in_priority_req),
    .in_record_id        (in_record_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_popped_valid    (out_popped_valid),
    .out_popped_priority (out_popped_priority),
    .out_popped_record   (out_popped_record),
    .out_entry_count     (out_entry_count)
  );

  always #HALF_PERIOD clk = ~clk;

  assign seen_result = {out_status, out_popped_valid, out_popped_priority,
                        out_popped_record, out_entry_count};

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_result);
  end

  // Receiver: serve a long hold when asked, otherwise stall at random.
  // The hold is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left   <= LONG_HOLD - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one input beat after random gaps; hold the payload until accepted,
  // then record the prediction for it.
  task automatic push_beat(logic act, logic [PRI_W-1:0] pri,
                           logic [RECORD_BITS-1:0] rec);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_priority_req <= pri;
    in_record_id    <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_beat(act, pri, rec);
    beats_offered++;
  endtask

  // Drop valid and wait for every predicted result to come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_burst(burst_t kind);
    case (kind)
      BURST_FILL: begin
        // overfill, then an unset level while full: invalid wins over full
        repeat (QUEUE_DEPTH + 2)
          push_beat(ACT_INSERT, PRI_W'($urandom_range(3, 1)), RECORD_BITS'($urandom));
        push_beat(ACT_INSERT, PRI_UNSET, RECORD_BITS'($urandom));
      end
      BURST_DRAIN: begin
        repeat (QUEUE_DEPTH + 2)
          push_beat(ACT_POP, PRI_W'($urandom), RECORD_BITS'($urandom));
      end
      BURST_MIX: begin
        repeat (24)
          push_beat(($urandom_range(99) < 55) ? ACT_INSERT : ACT_POP,
                    PRI_W'($urandom_range(3, 1)), RECORD_BITS'($urandom));
      end
      default: begin
        repeat (16)
          push_beat(1'($urandom), PRI_W'($urandom), RECORD_BITS'($urandom));
      end
    endcase
  endtask

  function automatic burst_t pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 12) return BURST_FILL;
    if (r < 24) return BURST_DRAIN;
    if (r < 80) return BURST_MIX;
    return BURST_NOISE;
  endfunction

  initial begin
    int phase_start;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, unset level on empty and non-empty queue,
    // each level with extreme handles, FIFO within a level, pops that
    // carry junk level and handle, and a pop that runs dry.
    push_beat(ACT_POP,    PRI_HIGH,  16'hffff);
    push_beat(ACT_INSERT, PRI_UNSET, 16'hffff);
    push_beat(ACT_INSERT, PRI_LOW,   16'h0000);
    push_beat(ACT_INSERT, PRI_MID,   16'hffff);
    push_beat(ACT_INSERT, PRI_HIGH,  16'h1234);
    push_beat(ACT_INSERT, PRI_LOW,   16'habcd);
    push_beat(ACT_INSERT, PRI_HIGH,  16'h5555);
    push_beat(ACT_INSERT, PRI_MID,   16'haaaa);
    push_beat(ACT_POP,    PRI_UNSET, 16'h0000);
    push_beat(ACT_INSERT, PRI_UNSET, 16'h0001);
    push_beat(ACT_INSERT, PRI_HIGH,  16'h0000);
    repeat (8) push_beat(ACT_POP, PRI_W'($urandom), RECORD_BITS'($urandom));
    settle();

    // Boundary: fill past depth, then drain past empty.
    run_burst(BURST_FILL);
    run_burst(BURST_DRAIN);
    settle();

    // Pressure: long output hold while the sender keeps offering beats.
    hold_request <= hold_request + 1;
    repeat (2) run_burst(BURST_MIX);
    settle();

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 80; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 80; end
        default: begin idle_pct = 23; stall_pct <= 23; end
      endcase
      phase_start = beats_offered;
      while (beats_offered - phase_start < PHASE_BEATS) run_burst(pick_burst());
      settle();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d beats: %0d entries popped, %0d empty pops,",
             beats_offered, sb.pops_returned, sb.empty_pops);
    $display("%0d unset levels, %0d full drops, peak occupancy %0d of %0d",
             sb.invalid_inserts, sb.full_drops, sb.peak_held, QUEUE_DEPTH);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
